// ----- rtl/ptcs_pkg.sv -----
// Shared types and constants for the peer table closest-select block.
`timescale 1ns / 1ps
`default_nettype none
package ptcs_pkg;

  localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
  // FNV prime is 2^40 + 0x1b3
  localparam int          FNV_PRIME_SHIFT = 40;
  localparam logic [63:0] FNV_PRIME_LO    = 64'h0000_0000_0000_01b3;
  localparam logic [5:0]  RESULT_CAP      = 6'd32;
  localparam logic [2:0]  HASH_BYTES      = 3'd6;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] peer_address;
    logic [15:0] peer_port_in;
    logic [63:0] timestamp;
    logic [63:0] target_id;
    logic [5:0]  want_count;
  } ptcs_req_t;

  typedef struct packed {
    logic        added;
    logic        valid_res;
    logic [63:0] result_id;
    logic [31:0] result_address;
    logic [15:0] result_port;
    logic [63:0] result_distance;
    logic        last;
  } ptcs_rsp_t;

  typedef struct packed {
    logic [63:0] id;
    logic [31:0] address;
    logic [15:0] port;
    logic [63:0] seen_time;
  } ptcs_entry_t;

  typedef enum logic [1:0] {
    RESP_NONE,
    RESP_STATUS,
    RESP_PEER
  } ptcs_resp_e;

  typedef struct packed {
    logic       load;
    logic       walk_clr;
    logic       walk_run;
    logic       shift_clr;
    logic       shifting;
    logic       hash_init;
    logic       hash_step;
    logic       write_new;
    logic       write_refresh;
    logic       mark_dead;
    logic       query_init;
    ptcs_resp_e resp;
    logic       added;
  } ptcs_ctl_t;

  typedef struct packed {
    logic walk_done;
    logic hit;
    logic full;
    logic victim;
    logic hash_done;
    logic q_more;
    logic k_zero;
  } ptcs_sts_t;

endpackage
`default_nettype wire

// ----- rtl/ptcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ptcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/ptcs_datapath.sv -----
// Datapath: peer table storage, table walker, hash unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module ptcs_datapath
  import ptcs_pkg::*;
#(
  parameter int MAX_PEERS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ptcs_req_t req_i,
  input  wire ptcs_ctl_t ctl_i,
  output      ptcs_sts_t sts_o,
  output      ptcs_rsp_t rsp_o,
  output      logic      rsp_strobe_o
);

  localparam int IW = $clog2(MAX_PEERS);
  localparam int CW = $clog2(MAX_PEERS + 1);
  localparam int MW = (CW > 6) ? CW : 6;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PEERS);
  localparam logic [IW-1:0] LAST_IDX   = IW'(MAX_PEERS - 1);

  // control state
  logic [CW-1:0]        count_q, count_d;
  logic [MAX_PEERS-1:0] live_q, live_d;
  logic [MAX_PEERS-1:0] used_q, used_d;
  logic [CW-1:0]        live_cnt_q, live_cnt_d;
  logic                 pend_q, pend_d;
  logic                 strobe_q, strobe_d;
  logic                 hit_q, hit_d;
  logic                 vic_q, vic_d;
  logic                 best_q, best_d;

  // payload
  ptcs_req_t   req_q, req_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [IW-1:0] pend_idx_q, pend_idx_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  ptcs_entry_t hit_ent_q, hit_ent_d;
  logic [IW-1:0] vic_idx_q, vic_idx_d;
  logic [63:0]   vic_time_q, vic_time_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  ptcs_entry_t best_ent_q, best_ent_d;
  logic [63:0]   best_dist_q, best_dist_d;
  logic [63:0]   hash_q, hash_d;
  logic [2:0]    hstep_q, hstep_d;
  logic [5:0]    k_q, k_d;
  logic [5:0]    n_q, n_d;
  ptcs_rsp_t     rsp_q, rsp_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  ptcs_entry_t   ram_wdata;
  ptcs_entry_t   ram_rdata;

  logic [47:0] hash_bytes;
  logic [63:0] hash_x;
  logic [63:0] xor_dist;
  logic [5:0]  want_cap;
  logic [IW-1:0] new_idx;

  ptcs_ram #(
    .WIDTH($bits(ptcs_entry_t)),
    .DEPTH(MAX_PEERS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_idx_q[IW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign hash_bytes = {req_q.peer_port_in, req_q.peer_address};
  assign hash_x     = hash_q ^ {56'd0, hash_bytes[8*hstep_q +: 8]};
  assign xor_dist   = ram_rdata.id ^ req_q.target_id;
  assign want_cap   = (req_i.want_count > RESULT_CAP) ? RESULT_CAP : req_i.want_count;
  assign new_idx    = (count_q == FULL_COUNT) ? LAST_IDX : count_q[IW-1:0];

  always_comb begin
    count_d     = count_q;
    live_d      = live_q;
    used_d      = used_q;
    live_cnt_d  = live_cnt_q;
    pend_d      = 1'b0;
    strobe_d    = 1'b0;
    hit_d       = hit_q;
    vic_d       = vic_q;
    best_d      = best_q;
    req_d       = req_q;
    rd_idx_d    = rd_idx_q;
    pend_idx_d  = pend_idx_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    vic_idx_d   = vic_idx_q;
    vic_time_d  = vic_time_q;
    best_idx_d  = best_idx_q;
    best_ent_d  = best_ent_q;
    best_dist_d = best_dist_q;
    hash_d      = hash_q;
    hstep_d     = hstep_q;
    k_d         = k_q;
    n_d         = n_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = new_idx;
    ram_wdata   = '0;

    if (ctl_i.load) begin
      req_d = req_i;
    end
    if (ctl_i.walk_clr) begin
      rd_idx_d = '0;
      hit_d    = 1'b0;
      vic_d    = 1'b0;
      best_d   = 1'b0;
    end
    if (ctl_i.walk_run && (rd_idx_q < count_q)) begin
      pend_d     = 1'b1;
      pend_idx_d = rd_idx_q[IW-1:0];
      rd_idx_d   = rd_idx_q + CW'(1);
    end
    if (ctl_i.shift_clr) begin
      rd_idx_d = CW'(vic_idx_q) + CW'(1);
      for (int i = 0; i < MAX_PEERS - 1; i++) begin
        if (i >= int'(vic_idx_q)) begin
          live_d[i] = live_q[i+1];
        end
      end
      live_d[MAX_PEERS-1] = 1'b0;
    end

    if (pend_q) begin
      if (ctl_i.shifting) begin
        ram_we    = 1'b1;
        ram_waddr = pend_idx_q - IW'(1);
        ram_wdata = ram_rdata;
      end else begin
        if (!hit_q && (ram_rdata.address == req_q.peer_address) &&
            (ram_rdata.port == req_q.peer_port_in)) begin
          hit_d     = 1'b1;
          hit_idx_d = pend_idx_q;
          hit_ent_d = ram_rdata;
        end
        if (!live_q[pend_idx_q] && (!vic_q || (ram_rdata.seen_time < vic_time_q))) begin
          vic_d      = 1'b1;
          vic_idx_d  = pend_idx_q;
          vic_time_d = ram_rdata.seen_time;
        end
        if (live_q[pend_idx_q] && !used_q[pend_idx_q] && (!best_q || (xor_dist < best_dist_q)))
        begin
          best_d      = 1'b1;
          best_idx_d  = pend_idx_q;
          best_ent_d  = ram_rdata;
          best_dist_d = xor_dist;
        end
      end
    end

    if (ctl_i.hash_init) begin
      hash_d  = FNV_BASIS;
      hstep_d = '0;
    end
    if (ctl_i.hash_step) begin
      hash_d  = (hash_x << FNV_PRIME_SHIFT) + 64'(hash_x * FNV_PRIME_LO);
      hstep_d = hstep_q + 3'd1;
    end

    if (ctl_i.write_new) begin
      ram_we    = 1'b1;
      ram_waddr = new_idx;
      ram_wdata = '{id: hash_q, address: req_q.peer_address,
                    port: req_q.peer_port_in, seen_time: req_q.timestamp};
      live_d[new_idx] = 1'b1;
      live_cnt_d      = live_cnt_q + CW'(1);
      if (count_q != FULL_COUNT) begin
        count_d = count_q + CW'(1);
      end
    end
    if (ctl_i.write_refresh) begin
      ram_we              = 1'b1;
      ram_waddr           = hit_idx_q;
      ram_wdata           = hit_ent_q;
      ram_wdata.seen_time = req_q.timestamp;
      live_d[hit_idx_q]   = 1'b1;
      if (!live_q[hit_idx_q]) begin
        live_cnt_d = live_cnt_q + CW'(1);
      end
    end
    if (ctl_i.mark_dead) begin
      live_d[hit_idx_q] = 1'b0;
      if (live_q[hit_idx_q]) begin
        live_cnt_d = live_cnt_q - CW'(1);
      end
    end

    if (ctl_i.query_init) begin
      used_d = '0;
      k_d    = '0;
      if (MW'(live_cnt_q) < MW'(want_cap)) begin
        n_d = 6'(live_cnt_q);
      end else begin
        n_d = want_cap;
      end
    end

    unique case (ctl_i.resp)
      RESP_STATUS: begin
        strobe_d    = 1'b1;
        rsp_d       = '0;
        rsp_d.added = ctl_i.added;
        rsp_d.last  = 1'b1;
      end
      RESP_PEER: begin
        strobe_d              = 1'b1;
        rsp_d.added           = 1'b0;
        rsp_d.valid_res       = 1'b1;
        rsp_d.result_id       = best_ent_q.id;
        rsp_d.result_address  = best_ent_q.address;
        rsp_d.result_port     = best_ent_q.port;
        rsp_d.result_distance = best_dist_q;
        rsp_d.last            = ((k_q + 6'd1) == n_q);
        used_d[best_idx_q]    = 1'b1;
        k_d                   = k_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      live_q     <= '0;
      used_q     <= '0;
      live_cnt_q <= '0;
      pend_q     <= 1'b0;
      strobe_q   <= 1'b0;
      hit_q      <= 1'b0;
      vic_q      <= 1'b0;
      best_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      live_q     <= live_d;
      used_q     <= used_d;
      live_cnt_q <= live_cnt_d;
      pend_q     <= pend_d;
      strobe_q   <= strobe_d;
      hit_q      <= hit_d;
      vic_q      <= vic_d;
      best_q     <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    rd_idx_q    <= rd_idx_d;
    pend_idx_q  <= pend_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_ent_q   <= hit_ent_d;
    vic_idx_q   <= vic_idx_d;
    vic_time_q  <= vic_time_d;
    best_idx_q  <= best_idx_d;
    best_ent_q  <= best_ent_d;
    best_dist_q <= best_dist_d;
    hash_q      <= hash_d;
    hstep_q     <= hstep_d;
    k_q         <= k_d;
    n_q         <= n_d;
    rsp_q       <= rsp_d;
  end

  assign sts_o.walk_done = (rd_idx_q >= count_q) && !pend_q;
  assign sts_o.hit       = hit_q;
  assign sts_o.full      = (count_q == FULL_COUNT);
  assign sts_o.victim    = vic_q;
  assign sts_o.hash_done = (hstep_q == HASH_BYTES);
  assign sts_o.q_more    = (k_q < n_q);
  assign sts_o.k_zero    = (k_q == 6'd0);

  assign rsp_o        = rsp_q;
  assign rsp_strobe_o = strobe_q;

  a_live_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_cnt_q == CW'($countones(live_q)))
    else $error("live counter out of step with live bits");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("entry count above table size");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (CW'(pend_idx_q) < count_q))
    else $error("table read beyond filled entries");

  a_peer_not_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && rsp_q.valid_res) |-> !rsp_q.added)
    else $error("peer transaction flagged as added");

endmodule
`default_nettype wire

// ----- rtl/ptcs_ctrl.sv -----
// Controller: sequences table walks, eviction, hashing and transaction output.
`timescale 1ns / 1ps
`default_nettype none
module ptcs_ctrl
  import ptcs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic [1:0] cmd_i,
  input  wire ptcs_sts_t sts_i,
  output      ptcs_ctl_t ctl_o,
  output      logic      busy_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SHIFT,
    S_HASH,
    S_QCHK,
    S_QSCAN
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cmd_q, cmd_d;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    ctl_o   = '0;
    ctl_o.resp = RESP_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d          = cmd_i;
          ctl_o.load     = 1'b1;
          ctl_o.walk_clr = 1'b1;
          unique case (cmd_i)
            CMD_ADD, CMD_MARK: state_d = S_FIND;
            CMD_QUERY: begin
              ctl_o.query_init = 1'b1;
              state_d          = S_QCHK;
            end
            default: ctl_o.resp = RESP_STATUS;
          endcase
        end
      end
      S_FIND: begin
        ctl_o.walk_run = 1'b1;
        if (sts_i.walk_done) begin
          if (cmd_q == CMD_MARK) begin
            ctl_o.mark_dead = sts_i.hit;
            ctl_o.resp      = RESP_STATUS;
            state_d         = S_IDLE;
          end else if (sts_i.hit) begin
            ctl_o.write_refresh = 1'b1;
            ctl_o.resp          = RESP_STATUS;
            state_d             = S_IDLE;
          end else if (!sts_i.full) begin
            ctl_o.hash_init = 1'b1;
            state_d         = S_HASH;
          end else if (sts_i.victim) begin
            ctl_o.shift_clr = 1'b1;
            state_d         = S_SHIFT;
          end else begin
            ctl_o.resp = RESP_STATUS;
            state_d    = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        ctl_o.shifting = 1'b1;
        ctl_o.walk_run = 1'b1;
        if (sts_i.walk_done) begin
          ctl_o.hash_init = 1'b1;
          state_d         = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          ctl_o.write_new = 1'b1;
          ctl_o.resp      = RESP_STATUS;
          ctl_o.added     = 1'b1;
          state_d         = S_IDLE;
        end else begin
          ctl_o.hash_step = 1'b1;
        end
      end
      S_QCHK: begin
        if (sts_i.q_more) begin
          ctl_o.walk_clr = 1'b1;
          state_d        = S_QSCAN;
        end else begin
          if (sts_i.k_zero) begin
            ctl_o.resp = RESP_STATUS;
          end
          state_d = S_IDLE;
        end
      end
      S_QSCAN: begin
        ctl_o.walk_run = 1'b1;
        if (sts_i.walk_done) begin
          ctl_o.resp = RESP_PEER;
          state_d    = S_QCHK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_ADD;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !ctl_o.load)
    else $error("request loaded while busy");

  a_shift_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> sts_i.full)
    else $error("eviction shift on a table that is not full");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ctl_o.write_new, ctl_o.write_refresh, ctl_o.mark_dead}) <= 1)
    else $error("conflicting table updates");

endmodule
`default_nettype wire

// ----- rtl/peer_table_closest_select_unit.sv -----
// Top level of the peer table with XOR-closest peer selection.
// Usage: drive req_i and raise start while busy is low; that cycle accepts
// the transaction. Commands: add/refresh, closest query, mark dead.
// Every add, mark-dead or unknown command yields one transaction on rsp_o
// with result_strobe_o high for one cycle and last set; added tells whether
// a new peer went in. A query yields min(want_count, 32, live peers)
// transactions in ascending XOR distance, the final one with last set, or
// one empty transaction when nothing qualifies.
// Each table walk reads one filled entry per cycle from the table RAM,
// which has a separate read port and write port. Mark dead and refresh
// take one walk; a new insert adds FNV hashing of the address and port,
// one byte per cycle; an eviction adds a shift walk over the entries after
// the victim. A query runs one walk per result.
// Results cannot be stalled; busy stays high until the last one is issued.
// Reset empties the table; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module peer_table_closest_select_unit
  import ptcs_pkg::*;
#(
  parameter int MAX_PEERS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output      logic      busy,
  input  wire ptcs_req_t req_i,
  output      ptcs_rsp_t rsp_o,
  output      logic      result_strobe_o
);

  ptcs_ctl_t ctl;
  ptcs_sts_t sts;

  ptcs_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .cmd_i (req_i.command),
    .sts_i (sts),
    .ctl_o (ctl),
    .busy_o(busy)
  );

  ptcs_datapath #(
    .MAX_PEERS(MAX_PEERS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .rsp_o       (rsp_o),
    .rsp_strobe_o(result_strobe_o)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the peer table closest-select unit: random and directed commands.
`timescale 1ns / 1ps
module tb;
  import ptcs_pkg::*;

  localparam int NPEERS = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  ptcs_req_t req_i = '0;
  ptcs_rsp_t rsp_o;
  logic      result_strobe_o;

  peer_table_closest_select_unit #(.MAX_PEERS(NPEERS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .rsp_o(rsp_o), .result_strobe_o(result_strobe_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] tbl_id [NPEERS];
  logic [31:0] tbl_addr [NPEERS];
  logic [15:0] tbl_port [NPEERS];
  logic [63:0] tbl_seen [NPEERS];
  logic        tbl_live [NPEERS];
  int          tbl_count = 0;

  ptcs_req_t pending_cmds[$];
  ptcs_rsp_t expected_rsps[$];
  int        mismatches = 0;

  // known peers for reuse in stimulus
  logic [31:0] known_addr[$];
  logic [15:0] known_port[$];

  function automatic logic [63:0] fnv_hash(logic [31:0] a, logic [15:0] p);
    logic [63:0] h;
    logic [7:0]  b;
    h = FNV_BASIS;
    for (int i = 0; i < 6; i++) begin
      b = (i < 4) ? a[8*i +: 8] : p[8*(i-4) +: 8];
      h = h ^ {56'd0, b};
      h = h * 64'd1099511628211;
    end
    return h;
  endfunction

  function automatic int find_peer(logic [31:0] a, logic [15:0] p);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_addr[i] == a && tbl_port[i] == p) return i;
    return -1;
  endfunction

  function automatic bit apply_add(ptcs_req_t r);
    int hit, victim;
    bit found;
    hit = find_peer(r.peer_address, r.peer_port_in);
    if (hit >= 0) begin
      tbl_seen[hit] = r.timestamp;
      tbl_live[hit] = 1'b1;
      return 1'b0;
    end
    if (tbl_count >= NPEERS) begin
      found = 1'b0;
      victim = 0;
      for (int i = 0; i < NPEERS; i++)
        if (!tbl_live[i] && (!found || tbl_seen[i] < tbl_seen[victim])) begin
          found = 1'b1;
          victim = i;
        end
      if (!found) return 1'b0;
      for (int i = victim; i + 1 < NPEERS; i++) begin
        tbl_id[i] = tbl_id[i+1];
        tbl_addr[i] = tbl_addr[i+1];
        tbl_port[i] = tbl_port[i+1];
        tbl_seen[i] = tbl_seen[i+1];
        tbl_live[i] = tbl_live[i+1];
      end
      tbl_count = NPEERS - 1;
    end
    tbl_id[tbl_count] = fnv_hash(r.peer_address, r.peer_port_in);
    tbl_addr[tbl_count] = r.peer_address;
    tbl_port[tbl_count] = r.peer_port_in;
    tbl_seen[tbl_count] = r.timestamp;
    tbl_live[tbl_count] = 1'b1;
    tbl_count++;
    return 1'b1;
  endfunction

  task automatic predict_table_op(ptcs_req_t r);
    ptcs_rsp_t o;
    bit        used [NPEERS];
    int        want, live, best, hit, n;
    logic [63:0] d, bd;
    o = '0;
    if (r.command == CMD_QUERY) begin
      want = (r.want_count > RESULT_CAP) ? RESULT_CAP : r.want_count;
      live = 0;
      for (int i = 0; i < tbl_count; i++) begin
        used[i] = 1'b0;
        if (tbl_live[i]) live++;
      end
      if (want > live) want = live;
      n = 0;
      for (int k = 0; k < want; k++) begin
        best = -1;
        bd = '0;
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_live[i] || used[i]) continue;
          d = tbl_id[i] ^ r.target_id;
          if (best < 0 || d < bd) begin
            best = i;
            bd = d;
          end
        end
        used[best] = 1'b1;
        o = '0;
        o.valid_res = 1'b1;
        o.result_id = tbl_id[best];
        o.result_address = tbl_addr[best];
        o.result_port = tbl_port[best];
        o.result_distance = bd;
        o.last = (k == want - 1);
        expected_rsps.push_back(o);
        n++;
      end
      if (n == 0) begin
        o = '0;
        o.last = 1'b1;
        expected_rsps.push_back(o);
      end
      return;
    end
    if (r.command == CMD_ADD) begin
      o.added = apply_add(r);
    end else if (r.command == CMD_MARK) begin
      hit = find_peer(r.peer_address, r.peer_port_in);
      if (hit >= 0) tbl_live[hit] = 1'b0;
    end
    o.last = 1'b1;
    expected_rsps.push_back(o);
  endtask

  // driver
  int gap = 0;
  int wait_draw = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_table_op(req_i);
        wait_draw = $urandom_range(0, 15);
        if (wait_draw == 0 && pending_cmds.size() > 0) begin
          req_i <= pending_cmds.pop_front();
        end else begin
          start <= 1'b0;
          gap <= wait_draw;
        end
      end else if (!start) begin
        if (gap > 0) begin
          gap <= gap - 1;
        end else if (pending_cmds.size() > 0) begin
          req_i <= pending_cmds.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // monitor
  ptcs_rsp_t exp_rsp;
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected transaction %h", rsp_o);
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp_o !== exp_rsp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: mismatch exp added=%b v=%b id=%h a=%h p=%h d=%h l=%b",
              exp_rsp.added, exp_rsp.valid_res, exp_rsp.result_id,
              exp_rsp.result_address, exp_rsp.result_port, exp_rsp.result_distance,
              exp_rsp.last);
            $display("        got added=%b v=%b id=%h a=%h p=%h d=%h l=%b",
              rsp_o.added, rsp_o.valid_res, rsp_o.result_id,
              rsp_o.result_address, rsp_o.result_port, rsp_o.result_distance,
              rsp_o.last);
          end
        end
      end
    end
  end

  // watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic ptcs_req_t make_cmd(logic [1:0] c, logic [31:0] a, logic [15:0] p,
                                         logic [63:0] ts, logic [63:0] tg, logic [5:0] w);
    ptcs_req_t r;
    r.command = c;
    r.peer_address = a;
    r.peer_port_in = p;
    r.timestamp = ts;
    r.target_id = tg;
    r.want_count = w;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_random_cmd();
    int sel, k;
    logic [31:0] a;
    logic [15:0] p;
    logic [63:0] ts;
    sel = $urandom_range(0, 99);
    ts = ($urandom_range(0, 9) == 0) ? '1 : rand64();
    if (known_addr.size() > 0 && $urandom_range(0, 1) == 1) begin
      k = $urandom_range(0, known_addr.size() - 1);
      a = known_addr[k];
      p = known_port[k];
    end else begin
      a = $urandom;
      p = 16'($urandom_range(0, 65535));
    end
    if (sel < 45) begin
      pending_cmds.push_back(make_cmd(CMD_ADD, a, p, ts, rand64(),
        6'($urandom_range(0, 63))));
      known_addr.push_back(a);
      known_port.push_back(p);
    end else if (sel < 70) begin
      pending_cmds.push_back(make_cmd(CMD_QUERY, $urandom, 16'($urandom_range(0, 65535)), ts,
        rand64(), 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, 8))));
    end else if (sel < 95) begin
      pending_cmds.push_back(make_cmd(CMD_MARK, a, p, ts, rand64(),
        6'($urandom_range(0, 63))));
    end else begin
      pending_cmds.push_back(make_cmd(2'd3, a, p, ts, rand64(),
        6'($urandom_range(0, 63))));
    end
  endtask

  initial begin
    // directed: empty query, extremes, refresh, mark-dead, unknown command
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, '0, 6'd5));
    pending_cmds.push_back(make_cmd(CMD_ADD, '0, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_ADD, '1, '1, '1, '1, '1));
    pending_cmds.push_back(make_cmd(CMD_ADD, '0, '0, 64'd7, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, '1, 6'd63));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, '0, 6'd0));
    pending_cmds.push_back(make_cmd(CMD_MARK, '1, '1, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_MARK, 32'h1234, 16'h1, '0, '0, '0));
    pending_cmds.push_back(make_cmd(2'd3, '1, '1, '1, '1, '1));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, 64'h5555_aaaa_5555_aaaa, 6'd32));
    // fill the table, then overfill with all live and with dead entries
    for (int i = 0; i < 33; i++)
      pending_cmds.push_back(make_cmd(CMD_ADD, 32'(32'h0a00_0000 + i), 16'(i), 64'(100 - i),
        '0, '0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, rand64(), 6'd32));
    pending_cmds.push_back(make_cmd(CMD_MARK, 32'h0a00_0003, 16'd3, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_MARK, 32'h0a00_0005, 16'd5, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_ADD, 32'hdead_beef, 16'hbeef, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_ADD, 32'hfeed_f00d, 16'h0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_QUERY, '0, '0, '0, rand64(), 6'd40));
    for (int i = 0; i < 112; i++) push_random_cmd();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_rsps.size() == 0 && !busy);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
